// File: rtl/srb_pkg.sv
`default_nettype none
package srb_pkg;

  localparam int CountWidth = 63;
  localparam logic [CountWidth-1:0] COUNT_MAX = {CountWidth{1'b1}};

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_RESET  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ORIGIN_UNKNOWN = 2'd0,
    ORIGIN_BOOT    = 2'd1,
    ORIGIN_QUERY   = 2'd2,
    ORIGIN_SESSION = 2'd3
  } origin_t;

  typedef enum logic [1:0] {
    DIN_NONE        = 2'd0,
    DIN_NATIVE_RST  = 2'd1,
    DIN_ORIGIN_CHG  = 2'd2,
    DIN_OTHER       = 2'd3
  } disc_in_t;

  typedef enum logic [2:0] {
    DOUT_NONE        = 3'd0,
    DOUT_STARTED     = 3'd1,
    DOUT_SESSION_RST = 3'd2,
    DOUT_NATIVE_RST  = 3'd3,
    DOUT_ORIGIN_CHG  = 3'd4
  } disc_out_t;

  typedef struct packed {
    logic               func;
    logic               header_valid;
    logic               is_step_counter;
    logic               timestamp_ok;
    logic signed [63:0] raw_count;
    logic [1:0]         origin;
    logic [63:0]        origin_tag;
    logic               has_query_interval;
    logic signed [63:0] query_start;
    logic signed [63:0] query_end;
    logic [1:0]         discontinuity_in;
    logic               stateful_reset_in;
  } sample_t;

  typedef struct packed {
    logic                  accepted;
    logic [CountWidth-1:0] session_count;
    logic [2:0]            discontinuity_out;
    logic                  count_saturated;
    logic                  stateful_reset_out;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/srb_sample_if.sv
`default_nettype none
interface srb_sample_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic               header_valid;
  logic               is_step_counter;
  logic               timestamp_ok;
  logic signed [63:0] raw_count;
  logic [1:0]         origin;
  logic [63:0]        origin_tag;
  logic               has_query_interval;
  logic signed [63:0] query_start;
  logic signed [63:0] query_end;
  logic [1:0]         discontinuity_in;
  logic               stateful_reset_in;

  modport source (
    output valid, func, header_valid, is_step_counter, timestamp_ok, raw_count, origin,
           origin_tag, has_query_interval, query_start, query_end, discontinuity_in,
           stateful_reset_in,
    input  ready
  );
  modport sink (
    input  valid, func, header_valid, is_step_counter, timestamp_ok, raw_count, origin,
           origin_tag, has_query_interval, query_start, query_end, discontinuity_in,
           stateful_reset_in,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/srb_result_if.sv
`default_nettype none
interface srb_result_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [62:0] session_count;
  logic [2:0]  discontinuity_out;
  logic        count_saturated;
  logic        stateful_reset_out;

  modport source (
    output valid, accepted, session_count, discontinuity_out, count_saturated,
           stateful_reset_out,
    input  ready
  );
  modport sink (
    input  valid, accepted, session_count, discontinuity_out, count_saturated,
           stateful_reset_out,
    output ready
  );
  modport monitor (
    input valid, ready, accepted, session_count, discontinuity_out, count_saturated,
          stateful_reset_out
  );
endinterface
`default_nettype wire

// File: rtl/srb_cfg_if.sv
`default_nettype none
interface srb_cfg_if;
  logic valid;
  logic ready;
  logic session_active;

  modport source (output valid, session_active, input ready);
  modport sink (input valid, session_active, output ready);
endinterface
`default_nettype wire

// File: rtl/step_count_session_rebaser.sv
// A sample is taken into the input register; its result is formed from there and captured in
// the result register, where it waits while the result side stalls.
// Throughput: one sample per cycle while the result side accepts; the state update and the result
// are formed combinationally between the input register and the result register.
// A baseline reset transaction yields no result.
// Reset (rst, synchronous, active high) clears the session flag, baseline and both stages.
`default_nettype none
module step_count_session_rebaser (
  input  wire logic clk,
  input  wire logic rst,
  srb_sample_if.sink  sample,
  srb_result_if.source result,
  srb_cfg_if.sink     cfg
);
  import srb_pkg::*;

  sample_t in_data;
  sample_t hold_data;
  result_t res;
  result_t out_data;
  logic    hold_valid;
  logic    advance;
  logic    has_result;
  logic    free;
  logic    load;

  assign in_data = '{
    func:               sample.func,
    header_valid:       sample.header_valid,
    is_step_counter:    sample.is_step_counter,
    timestamp_ok:       sample.timestamp_ok,
    raw_count:          sample.raw_count,
    origin:             sample.origin,
    origin_tag:         sample.origin_tag,
    has_query_interval: sample.has_query_interval,
    query_start:        sample.query_start,
    query_end:          sample.query_end,
    discontinuity_in:   sample.discontinuity_in,
    stateful_reset_in:  sample.stateful_reset_in
  };

  assign cfg.ready = 1'b1;

  // a baseline reset never waits on the result side
  assign advance = hold_valid && (!has_result || free);
  assign load    = advance && has_result;

  srb_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (sample.valid),
    .in_data    (in_data),
    .in_ready   (sample.ready),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  srb_core u_core (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg.valid),
    .cfg_session_active (cfg.session_active),
    .fire               (advance),
    .item               (hold_data),
    .has_result         (has_result),
    .res                (res)
  );

  srb_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_data (res),
    .free      (free),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_data  (out_data)
  );

  assign result.accepted           = out_data.accepted;
  assign result.session_count      = out_data.session_count;
  assign result.discontinuity_out  = out_data.discontinuity_out;
  assign result.count_saturated    = out_data.count_saturated;
  assign result.stateful_reset_out = out_data.stateful_reset_out;
endmodule
`default_nettype wire

// File: rtl/srb_in_stage.sv
`default_nettype none
module srb_in_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire srb_pkg::sample_t in_data,
  output logic                  in_ready,
  input  wire logic             advance,
  output logic                  hold_valid,
  output srb_pkg::sample_t      hold_data
);
  import srb_pkg::*;

  logic take;

  // a held item that moves on this cycle frees the slot for the next one
  assign in_ready = !hold_valid || advance;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_data <= in_data;
    end
  end
endmodule
`default_nettype wire

// File: rtl/srb_core.sv
`default_nettype none
module srb_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_session_active,
  input  wire logic             fire,
  input  wire srb_pkg::sample_t item,
  output logic                  has_result,
  output srb_pkg::result_t      res
);
  import srb_pkg::*;

  logic                  session_active;
  logic                  has_baseline;
  logic                  reset_pending;
  logic                  saturated_flag;
  logic [1:0]            last_origin;
  logic [63:0]           last_origin_tag;
  logic [63:0]           last_query_start;
  logic [CountWidth-1:0] baseline;
  logic [CountWidth-1:0] last_raw_count;
  logic [CountWidth-1:0] committed_count;
  logic [CountWidth-1:0] last_session_count;

  logic                  saturated_flag_next;
  logic [CountWidth-1:0] committed_count_next;
  logic [CountWidth-1:0] count;
  logic [2:0]            code;
  logic                  sample_ok;
  logic                  query_ok;
  logic                  origin_chg;
  logic                  rollback;
  logic                  disc;
  logic [CountWidth:0]   sum;
  logic                  sum_hit;

  assign has_result = (item.func == FUNC_SAMPLE);

  assign query_ok  = item.has_query_interval && (item.query_end >= item.query_start);
  assign sample_ok = session_active && item.header_valid && item.is_step_counter
                     && item.timestamp_ok && !item.raw_count[63] && (item.origin_tag != '0)
                     && ((item.origin == ORIGIN_BOOT)
                         || ((item.origin == ORIGIN_QUERY) && query_ok));

  assign origin_chg = has_baseline && ((item.origin != last_origin)
                      || (item.origin_tag != last_origin_tag)
                      || ((item.origin == ORIGIN_QUERY)
                          && (item.query_start != last_query_start)));
  assign rollback   = has_baseline && !origin_chg
                      && (item.raw_count[CountWidth-1:0] < last_raw_count);
  assign disc       = has_baseline && (origin_chg || rollback
                      || (item.discontinuity_in != DIN_NONE) || item.stateful_reset_in);

  // raw never sits below the baseline on the plain path, so no borrow reaches the top bit
  assign sum     = {1'b0, committed_count} + {1'b0, item.raw_count[CountWidth-1:0]}
                   - {1'b0, baseline};
  assign sum_hit = sum[CountWidth] || (sum[CountWidth-1:0] == COUNT_MAX);

  always_comb begin
    count                = '0;
    code                 = DOUT_NONE;
    committed_count_next = committed_count;
    saturated_flag_next  = saturated_flag;
    if (!has_baseline) begin
      committed_count_next = '0;
      saturated_flag_next  = 1'b0;
      code                 = reset_pending ? DOUT_SESSION_RST : DOUT_STARTED;
    end else if (disc) begin
      committed_count_next = last_session_count;
      count                = last_session_count;
      if (rollback || (item.discontinuity_in == DIN_NATIVE_RST)) begin
        code = DOUT_NATIVE_RST;
      end else if (origin_chg || (item.discontinuity_in == DIN_ORIGIN_CHG)) begin
        code = DOUT_ORIGIN_CHG;
      end else begin
        code = DOUT_STARTED;
      end
    end else if (sum_hit) begin
      // exact hit on the maximum clears the flag
      saturated_flag_next = sum[CountWidth];
      count               = COUNT_MAX;
    end else begin
      count = sum[CountWidth-1:0];
    end
  end

  always_comb begin
    res = '0;
    if (sample_ok) begin
      res.accepted           = 1'b1;
      res.session_count      = count;
      res.discontinuity_out  = code;
      res.count_saturated    = saturated_flag_next;
      res.stateful_reset_out = item.stateful_reset_in || (code != DOUT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_active <= 1'b0;
      has_baseline   <= 1'b0;
      reset_pending  <= 1'b0;
      saturated_flag <= 1'b0;
    end else begin
      if (cfg_we) begin
        session_active <= cfg_session_active;
      end
      if (fire) begin
        if (!has_result) begin
          has_baseline   <= 1'b0;
          reset_pending  <= 1'b1;
          saturated_flag <= 1'b0;
        end else if (sample_ok) begin
          has_baseline   <= 1'b1;
          saturated_flag <= saturated_flag_next;
          if (!has_baseline) begin
            reset_pending <= 1'b0;
          end
        end
      end
    end
  end

  // tracking payload: always rewritten by the first accepted sample after a baseline clear
  always_ff @(posedge clk) begin
    if (fire && has_result && sample_ok) begin
      last_origin        <= item.origin;
      last_origin_tag    <= item.origin_tag;
      last_query_start   <= (item.origin == ORIGIN_QUERY) ? item.query_start : 64'd0;
      last_raw_count     <= item.raw_count[CountWidth-1:0];
      last_session_count <= count;
      committed_count    <= committed_count_next;
      if (!has_baseline || disc) begin
        baseline <= item.raw_count[CountWidth-1:0];
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/srb_out_stage.sv
`default_nettype none
module srb_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire srb_pkg::result_t load_data,
  output logic                  free,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output srb_pkg::result_t      out_data
);
  import srb_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end
endmodule
`default_nettype wire

// File: rtl/srb_checker.sv
`default_nettype none
module srb_checker (
  input wire logic     clk,
  input wire logic     rst,
  srb_result_if.source result
);
  import srb_pkg::*;

  // hold a stalled result
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid)
    else $error("result valid dropped while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.accepted |-> (result.session_count == '0)
      && (result.discontinuity_out == DOUT_NONE) && !result.count_saturated
      && !result.stateful_reset_out)
    else $error("rejected sample carries non-zero fields");

  a_disc_flags_reset: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.discontinuity_out != DOUT_NONE) |-> result.stateful_reset_out)
    else $error("discontinuity without stateful reset flag");

  a_sat_at_max: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.count_saturated |-> (result.session_count == COUNT_MAX))
    else $error("saturation flag with count below maximum");
endmodule

bind step_count_session_rebaser srb_checker u_srb_checker (
  .clk    (clk),
  .rst    (rst),
  .result (result)
);
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import srb_pkg::*;

  localparam logic [63:0] SAT_LIMIT  = {1'b0, COUNT_MAX};
  localparam logic [63:0] RAW_MIN    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TAG_LO     = 64'd1;
  localparam logic [63:0] TAG_HI     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam result_t     REJECTED   = '0;
  localparam int          PHASES     = 6;
  localparam int          PER_PHASE  = 313;

  typedef enum bit {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    bit        cfg_value;
    sample_t   item;
    bit        typed;
    result_t   want;
  } stim_row_t;

  logic clk;
  logic rst;

  srb_sample_if sample_ch ();
  srb_result_if result_ch ();
  srb_cfg_if    cfg_ch ();

  step_count_session_rebaser dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // predictor state
  bit          session_on;
  bit          base_set;
  bit          reset_pend;
  bit          sat_seen;
  logic [1:0]  prev_origin;
  logic [63:0] prev_tag;
  logic [63:0] prev_qstart;
  logic [63:0] base_raw;
  logic [63:0] prev_raw;
  logic [63:0] committed;
  logic [63:0] prev_count;

  result_t     pending_reports [$];
  stim_row_t   directed_rows [$];
  int          mismatches;
  bit          row_typed;
  result_t     row_want;
  bit          src_burst;
  bit          sink_burst;

  // random stream that most samples follow
  logic [1:0]  stream_origin = ORIGIN_BOOT;
  logic [63:0] stream_tag    = TAG_LO;
  logic [63:0] stream_qs     = '0;
  logic [63:0] stream_raw    = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    #10000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap(bit burst);
    int roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void forget_baseline();
    base_set    = 1'b0;
    sat_seen    = 1'b0;
    prev_origin = ORIGIN_UNKNOWN;
    prev_tag    = '0;
    prev_qstart = '0;
    base_raw    = '0;
    prev_raw    = '0;
    committed   = '0;
    prev_count  = '0;
  endfunction

  function automatic bit rebase_sample(input sample_t s, output result_t r);
    bit          ok;
    bit          moved;
    bit          wound_back;
    bit          rebase;
    disc_out_t   cause;
    logic [63:0] delta;
    logic [63:0] total;
    r     = '0;
    cause = DOUT_NONE;
    total = '0;
    if (s.func == FUNC_RESET) begin
      forget_baseline();
      reset_pend = 1'b1;
      return 1'b0;
    end
    ok = session_on && s.header_valid && s.is_step_counter && s.timestamp_ok
         && !s.raw_count[63] && s.origin_tag != '0
         && (s.origin == ORIGIN_BOOT || s.origin == ORIGIN_QUERY);
    if (ok && s.origin == ORIGIN_QUERY)
      ok = s.has_query_interval && ($signed(s.query_end) >= $signed(s.query_start));
    if (!ok) return 1'b1;

    moved = base_set && (s.origin != prev_origin || s.origin_tag != prev_tag
            || (s.origin == ORIGIN_QUERY && $unsigned(s.query_start) != prev_qstart));
    wound_back = base_set && !moved && ($unsigned(s.raw_count) < prev_raw);
    rebase = base_set && (moved || wound_back || s.discontinuity_in != DIN_NONE
             || s.stateful_reset_in);

    if (!base_set) begin
      base_raw   = s.raw_count;
      committed  = '0;
      prev_count = '0;
      sat_seen   = 1'b0;
      cause      = reset_pend ? DOUT_SESSION_RST : DOUT_STARTED;
      reset_pend = 1'b0;
      base_set   = 1'b1;
    end else if (rebase) begin
      // carry the last reported count over and restart from the new raw value
      committed = prev_count;
      base_raw  = s.raw_count;
      total     = committed;
      if (wound_back || s.discontinuity_in == DIN_NATIVE_RST) cause = DOUT_NATIVE_RST;
      else if (moved || s.discontinuity_in == DIN_ORIGIN_CHG) cause = DOUT_ORIGIN_CHG;
      else cause = DOUT_STARTED;
    end else begin
      delta = $unsigned(s.raw_count) - base_raw;
      if (delta > SAT_LIMIT) delta = SAT_LIMIT;
      if (committed >= SAT_LIMIT - delta) begin
        sat_seen = committed > SAT_LIMIT - delta;
        total    = SAT_LIMIT;
      end else begin
        total = committed + delta;
      end
    end

    prev_origin = s.origin;
    prev_tag    = s.origin_tag;
    prev_qstart = (s.origin == ORIGIN_QUERY) ? $unsigned(s.query_start) : '0;
    prev_raw    = s.raw_count;
    prev_count  = total;

    r.accepted           = 1'b1;
    r.session_count      = total[62:0];
    r.discontinuity_out  = cause;
    r.count_saturated    = sat_seen;
    r.stateful_reset_out = s.stateful_reset_in || cause != DOUT_NONE;
    return 1'b1;
  endfunction

  function automatic result_t report(bit acc, logic [63:0] cnt, disc_out_t code, bit sat,
                                     bit sr);
    result_t r;
    r.accepted           = acc;
    r.session_count      = cnt[62:0];
    r.discontinuity_out  = code;
    r.count_saturated    = sat;
    r.stateful_reset_out = sr;
    return r;
  endfunction

  function automatic sample_t boot_item(logic [63:0] raw, logic [63:0] tag);
    sample_t s;
    s                 = '0;
    s.func            = FUNC_SAMPLE;
    s.header_valid    = 1'b1;
    s.is_step_counter = 1'b1;
    s.timestamp_ok    = 1'b1;
    s.raw_count       = raw;
    s.origin          = ORIGIN_BOOT;
    s.origin_tag      = tag;
    return s;
  endfunction

  function automatic sample_t query_item(logic [63:0] raw, logic [63:0] tag,
                                         logic [63:0] qs, logic [63:0] qe);
    sample_t s;
    s                    = boot_item(raw, tag);
    s.origin             = ORIGIN_QUERY;
    s.has_query_interval = 1'b1;
    s.query_start        = qs;
    s.query_end          = qe;
    return s;
  endfunction

  function automatic sample_t noise_sample();
    sample_t s;
    s.func               = FUNC_SAMPLE;
    s.header_valid       = 1'($urandom_range(0, 1));
    s.is_step_counter    = 1'($urandom_range(0, 1));
    s.timestamp_ok       = 1'($urandom_range(0, 1));
    s.raw_count          = rand64();
    s.origin             = 2'($urandom_range(0, 3));
    s.origin_tag         = rand64();
    s.has_query_interval = 1'($urandom_range(0, 1));
    s.query_start        = rand64();
    s.query_end          = rand64();
    s.discontinuity_in   = 2'($urandom_range(0, 3));
    s.stateful_reset_in  = 1'($urandom_range(0, 1));
    return s;
  endfunction

  function automatic void match_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_sample(sample_t s, bit typed, result_t want);
    directed_rows.push_back('{ROW_SAMPLE, 1'b0, s, typed, want});
  endtask

  task automatic send_sample(sample_t s, bit typed, result_t want);
    int gap;
    gap = pick_gap(src_burst);
    repeat (gap) begin
      @(negedge clk);
      sample_ch.valid <= 1'b0;
    end
    @(negedge clk);
    sample_ch.valid              <= 1'b1;
    sample_ch.func               <= s.func;
    sample_ch.header_valid       <= s.header_valid;
    sample_ch.is_step_counter    <= s.is_step_counter;
    sample_ch.timestamp_ok       <= s.timestamp_ok;
    sample_ch.raw_count          <= s.raw_count;
    sample_ch.origin             <= s.origin;
    sample_ch.origin_tag         <= s.origin_tag;
    sample_ch.has_query_interval <= s.has_query_interval;
    sample_ch.query_start        <= s.query_start;
    sample_ch.query_end          <= s.query_end;
    sample_ch.discontinuity_in   <= s.discontinuity_in;
    sample_ch.stateful_reset_in  <= s.stateful_reset_in;
    row_typed = typed;
    row_want  = want;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
    if ($urandom_range(0, 49) == 0) src_burst = !src_burst;
  endtask

  // drop valid, wait for every report, then let a baseline reset drain too
  task automatic settle();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_session(bit value);
    settle();
    @(negedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.session_active <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    session_on = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    result_ch.ready = 1'b0;
    forever begin
      stall = pick_gap(sink_burst);
      repeat (stall) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
      end
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk);
        result_ch.ready <= 1'b1;
      end
      if ($urandom_range(0, 29) == 0) sink_burst = !sink_burst;
    end
  end

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    result_t pred;
    sample_t seen;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got.accepted           = result_ch.accepted;
        got.session_count      = result_ch.session_count;
        got.discontinuity_out  = result_ch.discontinuity_out;
        got.count_saturated    = result_ch.count_saturated;
        got.stateful_reset_out = result_ch.stateful_reset_out;
        if (pending_reports.size() == 0) begin
          $error("result transaction with no sample waiting for it");
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          match_field("accepted", 64'(want.accepted), 64'(got.accepted));
          match_field("session_count", 64'(want.session_count), 64'(got.session_count));
          match_field("discontinuity_out", 64'(want.discontinuity_out),
                      64'(got.discontinuity_out));
          match_field("count_saturated", 64'(want.count_saturated),
                      64'(got.count_saturated));
          match_field("stateful_reset_out", 64'(want.stateful_reset_out),
                      64'(got.stateful_reset_out));
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        seen.func               = sample_ch.func;
        seen.header_valid       = sample_ch.header_valid;
        seen.is_step_counter    = sample_ch.is_step_counter;
        seen.timestamp_ok       = sample_ch.timestamp_ok;
        seen.raw_count          = sample_ch.raw_count;
        seen.origin             = sample_ch.origin;
        seen.origin_tag         = sample_ch.origin_tag;
        seen.has_query_interval = sample_ch.has_query_interval;
        seen.query_start        = sample_ch.query_start;
        seen.query_end          = sample_ch.query_end;
        seen.discontinuity_in   = sample_ch.discontinuity_in;
        seen.stateful_reset_in  = sample_ch.stateful_reset_in;
        // typed rows still run through the predictor to keep its state in step
        if (rebase_sample(seen, pred))
          pending_reports.push_back(row_typed ? row_want : pred);
      end
    end
  end

  initial begin : stimulus
    sample_t s;
    sample_t good;
    sample_t bad;
    int      roll;
    int      pick;
    bit      phase_active [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    rst                          = 1'b1;
    sample_ch.valid              = 1'b0;
    sample_ch.func               = FUNC_SAMPLE;
    sample_ch.header_valid       = 1'b0;
    sample_ch.is_step_counter    = 1'b0;
    sample_ch.timestamp_ok       = 1'b0;
    sample_ch.raw_count          = '0;
    sample_ch.origin             = ORIGIN_UNKNOWN;
    sample_ch.origin_tag         = '0;
    sample_ch.has_query_interval = 1'b0;
    sample_ch.query_start        = '0;
    sample_ch.query_end          = '0;
    sample_ch.discontinuity_in   = DIN_NONE;
    sample_ch.stateful_reset_in  = 1'b0;
    cfg_ch.valid                 = 1'b0;
    cfg_ch.session_active        = 1'b0;
    session_on                   = 1'b0;
    reset_pend                   = 1'b0;
    forget_baseline();

    // no session yet: reject, but a baseline reset still registers
    add_sample(boot_item(64'd100, TAG_LO), 1'b1, REJECTED);
    s      = boot_item('0, TAG_LO);
    s.func = FUNC_RESET;
    add_sample(s, 1'b0, REJECTED);
    directed_rows.push_back('{ROW_CFG, 1'b1, sample_t'('0), 1'b0, REJECTED});
    add_sample(boot_item('0, TAG_LO), 1'b1,
               report(1'b1, 64'd0, DOUT_SESSION_RST, 1'b0, 1'b1));
    add_sample(boot_item(64'd100, TAG_LO), 1'b1,
               report(1'b1, 64'd100, DOUT_NONE, 1'b0, 1'b0));
    add_sample(boot_item(64'd50, TAG_LO), 1'b1,
               report(1'b1, 64'd100, DOUT_NATIVE_RST, 1'b0, 1'b1));
    add_sample(boot_item(SAT_LIMIT, TAG_LO), 1'b1,
               report(1'b1, SAT_LIMIT, DOUT_NONE, 1'b1, 1'b0));
    s                  = boot_item(SAT_LIMIT, TAG_LO);
    s.discontinuity_in = DIN_OTHER;
    add_sample(s, 1'b0, REJECTED);
    // exact hit on the limit clears the flag
    add_sample(boot_item(SAT_LIMIT, TAG_LO), 1'b0, REJECTED);
    s      = boot_item('0, TAG_LO);
    s.func = FUNC_RESET;
    add_sample(s, 1'b0, REJECTED);
    add_sample(boot_item(SAT_LIMIT, TAG_LO), 1'b1,
               report(1'b1, 64'd0, DOUT_SESSION_RST, 1'b0, 1'b1));
    add_sample(boot_item(64'd5, TAG_HI), 1'b0, REJECTED);
    add_sample(query_item(64'd10, TAG_HI, RAW_MIN, SAT_LIMIT), 1'b0, REJECTED);
    add_sample(query_item(64'd20, TAG_HI, RAW_MIN, RAW_MIN), 1'b0, REJECTED);
    add_sample(query_item(64'd30, TAG_HI, '0, '0), 1'b0, REJECTED);
    s                  = query_item(64'd40, TAG_HI, '0, 64'd9);
    s.discontinuity_in = DIN_NATIVE_RST;
    add_sample(s, 1'b0, REJECTED);
    s.raw_count        = 64'd50;
    s.discontinuity_in = DIN_ORIGIN_CHG;
    add_sample(s, 1'b0, REJECTED);
    s.raw_count         = 64'd60;
    s.discontinuity_in  = DIN_NONE;
    s.stateful_reset_in = 1'b1;
    add_sample(s, 1'b0, REJECTED);

    good = query_item(64'd70, TAG_HI, '0, 64'd9);
    bad = good; bad.header_valid = 1'b0;       add_sample(bad, 1'b1, REJECTED);
    bad = good; bad.is_step_counter = 1'b0;    add_sample(bad, 1'b1, REJECTED);
    bad = good; bad.timestamp_ok = 1'b0;       add_sample(bad, 1'b1, REJECTED);
    bad = good; bad.raw_count = RAW_MIN;       add_sample(bad, 1'b1, REJECTED);
    bad = good; bad.origin_tag = '0;           add_sample(bad, 1'b1, REJECTED);
    bad = good; bad.origin = ORIGIN_UNKNOWN;   add_sample(bad, 1'b1, REJECTED);
    bad = good; bad.origin = ORIGIN_SESSION;   add_sample(bad, 1'b1, REJECTED);
    bad = good; bad.has_query_interval = 1'b0; add_sample(bad, 1'b1, REJECTED);
    bad = good; bad.query_end = '1;            add_sample(bad, 1'b1, REJECTED);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) write_session(directed_rows[i].cfg_value);
      else send_sample(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_session(phase_active[ph]);
      repeat (PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          s      = noise_sample();
          s.func = FUNC_RESET;
        end else if (roll < 13) begin
          s = noise_sample();
        end else begin
          // advance the stream, then build a well-formed sample from it
          pick = $urandom_range(0, 99);
          if (pick < 4) begin
            stream_origin = $urandom_range(0, 1) ? ORIGIN_QUERY : ORIGIN_BOOT;
            if ($urandom_range(0, 3) != 0) stream_tag = rand64();
            if (stream_tag == '0) stream_tag = TAG_LO;
            stream_qs = rand64();
          end else if (pick < 7) begin
            stream_qs = stream_qs + 64'($urandom_range(1, 1000));
          end else if (pick < 12) begin
            stream_raw = stream_raw >> $urandom_range(1, 8);
          end else if (pick < 15) begin
            stream_raw = SAT_LIMIT - 64'($urandom_range(0, 1000));
          end else begin
            stream_raw = stream_raw + 64'($urandom_range(0, 500));
            if (stream_raw[63]) stream_raw = SAT_LIMIT;
          end
          s                   = noise_sample();
          s.header_valid      = 1'b1;
          s.is_step_counter   = 1'b1;
          s.timestamp_ok      = 1'b1;
          s.raw_count         = stream_raw;
          s.origin            = stream_origin;
          s.origin_tag        = stream_tag;
          s.discontinuity_in  = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3))
                                                             : DIN_NONE;
          s.stateful_reset_in = ($urandom_range(0, 19) == 0);
          if (stream_origin == ORIGIN_QUERY) begin
            s.has_query_interval = 1'b1;
            s.query_start        = stream_qs;
            s.query_end          = stream_qs + 64'($urandom_range(0, 1 << 20));
          end
          // break one validity condition in a share of them
          if (roll < 23) begin
            case ($urandom_range(0, 8))
              0: s.header_valid = 1'b0;
              1: s.is_step_counter = 1'b0;
              2: s.timestamp_ok = 1'b0;
              3: s.raw_count[63] = 1'b1;
              4: s.origin_tag = '0;
              5: s.origin = ORIGIN_UNKNOWN;
              6: s.origin = ORIGIN_SESSION;
              7: begin
                s.origin             = ORIGIN_QUERY;
                s.has_query_interval = 1'b0;
              end
              default: begin
                s.origin             = ORIGIN_QUERY;
                s.has_query_interval = 1'b1;
                s.query_end          = s.query_start - 64'd1
                                       - 64'($urandom_range(0, 1000));
              end
            endcase
          end
        end
        send_sample(s, 1'b0, REJECTED);
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: step_count_session_rebaser.f
rtl/srb_pkg.sv
rtl/srb_sample_if.sv
rtl/srb_result_if.sv
rtl/srb_cfg_if.sv
rtl/srb_in_stage.sv
rtl/srb_core.sv
rtl/srb_out_stage.sv
rtl/step_count_session_rebaser.sv
rtl/srb_checker.sv
bench/tb.sv
